// File: hdl/wsad_pkg.sv
`default_nettype none

package wsad_pkg;

    localparam int SAMPLE_W = 32;
    localparam int ACC_W    = 64;

    // Entries in the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified sample as handed from the front to the back.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] diff;
        logic                last;
        logic                too_long;
    } wsad_item_t;

    localparam int ITEM_W = $bits(wsad_item_t);

endpackage

`default_nettype wire

// File: hdl/wsad_front.sv
`default_nettype none

module wsad_front #(
    parameter int MAX_SAMPLES = 4096,
    parameter int POS_W       = $clog2(MAX_SAMPLES)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [wsad_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire logic                           in_last,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output wsad_pkg::wsad_item_t                push_item,
    output logic [POS_W-1:0]                    push_position
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SAMPLES - 1);

    logic [wsad_pkg::SAMPLE_W-1:0] previous_sample_reg, previous_sample_next;
    logic [POS_W-1:0]              position_reg, position_next;
    logic                          first_pending_reg, first_pending_next;
    logic                          overflowed_reg, overflowed_next;
    logic [wsad_pkg::SAMPLE_W-1:0] abs_diff;
    logic                          accepted;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accepted   = in_valid && push_ready;

    assign abs_diff = (in_sample > previous_sample_reg) ? in_sample - previous_sample_reg
                                                        : previous_sample_reg - in_sample;

    always_comb begin
        push_item.sample   = in_sample;
        push_item.diff     = first_pending_reg ? '0 : abs_diff;
        push_item.last     = in_last;
        push_item.too_long = overflowed_reg;
        push_position      = position_reg;
    end

    always_comb begin
        previous_sample_next = previous_sample_reg;
        position_next        = position_reg;
        first_pending_next   = first_pending_reg;
        overflowed_next      = overflowed_reg;
        if (accepted) begin
            previous_sample_next = in_sample;
            if (in_last) begin
                position_next      = '0;
                first_pending_next = 1'b1;
                overflowed_next    = 1'b0;
            end else begin
                first_pending_next = 1'b0;
                // The position counter wraps, and the window is then marked too long.
                if (position_reg == POS_LAST) begin
                    position_next   = '0;
                    overflowed_next = 1'b1;
                end else begin
                    position_next = position_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_sample_reg <= '0;
            position_reg        <= '0;
            first_pending_reg   <= 1'b1;
            overflowed_reg      <= 1'b0;
        end else begin
            previous_sample_reg <= previous_sample_next;
            position_reg        <= position_next;
            first_pending_reg   <= first_pending_next;
            overflowed_reg      <= overflowed_next;
        end
    end

`ifndef SYNTHESIS
    a_overflow_not_first: assert property (@(posedge aclk) disable iff (!aresetn)
        overflowed_reg |-> !first_pending_reg)
        else $error("overflow flag set at the start of a window");
`endif

endmodule

`default_nettype wire

// File: hdl/wsad_queue.sv
`default_nettype none

module wsad_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);

    localparam logic [wsad_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        wsad_pkg::QUEUE_CNT_W'(wsad_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0]                 entries_reg [wsad_pkg::QUEUE_DEPTH];
    logic [wsad_pkg::QUEUE_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wsad_pkg::QUEUE_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wsad_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                             do_push, do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

// File: hdl/wsad_back.sv
`default_nettype none

module wsad_back #(
    parameter int POS_W = 12
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         include_weighted,
    input  wire logic                         head_valid,
    input  wire wsad_pkg::wsad_item_t         head_item,
    input  wire logic [POS_W-1:0]             head_position,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [wsad_pkg::ACC_W-1:0]        out_total,
    output logic [wsad_pkg::ACC_W-1:0]        out_abs_diff_total,
    output logic [wsad_pkg::ACC_W-1:0]        out_weighted_total,
    output logic                              out_too_long
);

    localparam int PROD_W = POS_W + wsad_pkg::SAMPLE_W;

    logic                         advance;
    logic [PROD_W-1:0]            product;

    logic                         a_valid_reg;
    wsad_pkg::wsad_item_t         a_item_reg;
    logic [PROD_W-1:0]            a_prod_reg;

    logic [wsad_pkg::ACC_W-1:0]   sum_acc_reg, sum_acc_next;
    logic [wsad_pkg::ACC_W-1:0]   diff_acc_reg, diff_acc_next;
    logic [wsad_pkg::ACC_W-1:0]   weighted_acc_reg, weighted_acc_next;
    logic [wsad_pkg::ACC_W-1:0]   sum_new, diff_new, weighted_new;

    logic                         out_valid_reg, out_valid_next;
    logic [wsad_pkg::ACC_W-1:0]   out_total_reg, out_total_next;
    logic [wsad_pkg::ACC_W-1:0]   out_diff_reg, out_diff_next;
    logic [wsad_pkg::ACC_W-1:0]   out_weighted_reg, out_weighted_next;
    logic                         out_too_long_reg, out_too_long_next;

    // The whole back part moves only while the result register is free or being emptied.
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && head_valid;

    assign product = {{wsad_pkg::SAMPLE_W{1'b0}}, head_position}
                   * {{POS_W{1'b0}}, head_item.sample};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_item_reg <= head_item;
            a_prod_reg <= product;
        end
    end

    assign sum_new      = sum_acc_reg + wsad_pkg::ACC_W'(a_item_reg.sample);
    assign diff_new     = diff_acc_reg + wsad_pkg::ACC_W'(a_item_reg.diff);
    assign weighted_new = weighted_acc_reg + wsad_pkg::ACC_W'(a_prod_reg);

    always_comb begin
        sum_acc_next      = sum_acc_reg;
        diff_acc_next     = diff_acc_reg;
        weighted_acc_next = weighted_acc_reg;
        out_valid_next    = out_valid_reg;
        out_total_next    = out_total_reg;
        out_diff_next     = out_diff_reg;
        out_weighted_next = out_weighted_reg;
        out_too_long_next = out_too_long_reg;
        if (advance) begin
            out_valid_next = 1'b0;
            if (a_valid_reg) begin
                if (a_item_reg.last) begin
                    out_valid_next    = 1'b1;
                    out_total_next    = sum_new;
                    out_diff_next     = diff_new;
                    out_weighted_next = include_weighted ? weighted_new : '0;
                    out_too_long_next = a_item_reg.too_long;
                    sum_acc_next      = '0;
                    diff_acc_next     = '0;
                    weighted_acc_next = '0;
                end else begin
                    sum_acc_next      = sum_new;
                    diff_acc_next     = diff_new;
                    weighted_acc_next = weighted_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_acc_reg      <= '0;
            diff_acc_reg     <= '0;
            weighted_acc_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            sum_acc_reg      <= sum_acc_next;
            diff_acc_reg     <= diff_acc_next;
            weighted_acc_reg <= weighted_acc_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_total_reg    <= out_total_next;
        out_diff_reg     <= out_diff_next;
        out_weighted_reg <= out_weighted_next;
        out_too_long_reg <= out_too_long_next;
    end

    assign out_valid          = out_valid_reg;
    assign out_total          = out_total_reg;
    assign out_abs_diff_total = out_diff_reg;
    assign out_weighted_total = out_weighted_reg;
    assign out_too_long       = out_too_long_reg;

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(a_valid_reg && a_item_reg.last && advance))
        else $error("result raised without a closing sample");

    a_clear_after_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && a_valid_reg && a_item_reg.last)
            |=> (sum_acc_reg == '0 && diff_acc_reg == '0 && weighted_acc_reg == '0))
        else $error("sums not cleared after a window");
`endif

endmodule

`default_nettype wire

// File: hdl/window_sum_weighted_absdiff.sv
// m_tvalid rises after the last sample passes the queue, stage A and the result register.
// Throughput: one sample per cycle while m_tready stays high; the four-entry queue between
// the classifying front and the accumulating back absorbs short stalls on either side.
// The back part is a two-stage pipeline: position times sample, then three 64-bit adds.
// Reset (aresetn low, synchronous) empties the queue, clears all sums and window state,
// and sets include_weighted to 1.
`default_nettype none

module window_sum_weighted_absdiff #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data,     // include_weighted
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,      // sample
    input  wire logic         s_tlast,      // last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [191:0]      m_tdata,      // total, abs_diff_total, weighted_total
    output logic              m_tuser       // too_long
);

    localparam int POS_W   = $clog2(MAX_SAMPLES);
    localparam int ENTRY_W = wsad_pkg::ITEM_W + POS_W;

    logic                 include_weighted_reg, include_weighted_next;
    logic                 push_valid, push_ready;
    wsad_pkg::wsad_item_t push_item;
    logic [POS_W-1:0]     push_position;
    logic                 pop, head_valid;
    logic [ENTRY_W-1:0]   head_entry;
    wsad_pkg::wsad_item_t head_item;
    logic [POS_W-1:0]     head_position;
    logic [63:0]          total, abs_diff_total, weighted_total;

    assign cfg_ready             = 1'b1;
    assign include_weighted_next = (cfg_valid && cfg_ready) ? cfg_data : include_weighted_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            include_weighted_reg <= 1'b1;
        end else begin
            include_weighted_reg <= include_weighted_next;
        end
    end

    wsad_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .POS_W       (POS_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_sample     (s_tdata),
        .in_last       (s_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item),
        .push_position (push_position)
    );

    wsad_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_position, push_item}),
        .pop        (pop),
        .pop_valid  (head_valid),
        .pop_data   (head_entry)
    );

    assign head_item     = head_entry[wsad_pkg::ITEM_W-1:0];
    assign head_position = head_entry[ENTRY_W-1:wsad_pkg::ITEM_W];

    wsad_back #(
        .POS_W (POS_W)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .include_weighted   (include_weighted_reg),
        .head_valid         (head_valid),
        .head_item          (head_item),
        .head_position      (head_position),
        .pop                (pop),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_total          (total),
        .out_abs_diff_total (abs_diff_total),
        .out_weighted_total (weighted_total),
        .out_too_long       (m_tuser)
    );

    assign m_tdata = {weighted_total, abs_diff_total, total};

endmodule

`default_nettype wire

// File: tb/tb_window_sum_weighted_absdiff.sv
`timescale 1ns / 100ps

module tb_window_sum_weighted_absdiff;

    localparam int ACC_W          = wsad_pkg::ACC_W;
    localparam int SAMPLE_W       = wsad_pkg::SAMPLE_W;
    localparam int WINDOW_MAX     = 4096;
    localparam int RESULT_LATENCY = 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_SAMPLES = 800;
    localparam int PRINT_LIMIT    = 100;

    typedef struct packed {
        logic [ACC_W-1:0] total;
        logic [ACC_W-1:0] abs_diff_total;
        logic [ACC_W-1:0] weighted_total;
        logic             too_long;
    } window_sums_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data  = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;     // sample
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [3*ACC_W-1:0]    m_tdata;            // total, abs_diff_total, weighted_total
    logic                  m_tuser;            // too_long

    // Window state kept by the testbench alongside the block.
    logic                  weight_enable = 1'b1;
    logic [SAMPLE_W-1:0]   prev_sample   = '0;
    int                    sample_pos    = 0;
    logic                  window_open   = 1'b0;
    logic                  wrapped       = 1'b0;
    logic [ACC_W-1:0]      sum_run       = '0;
    logic [ACC_W-1:0]      diff_run      = '0;
    logic [ACC_W-1:0]      weighted_run  = '0;
    window_sums_t          expected_sums[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int cycle_count    = 0;
    int stall_mode     = 0;
    int stall_timer    = 0;

    window_sum_weighted_absdiff #(
        .MAX_SAMPLES (WINDOW_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                   input logic [ACC_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [ACC_W-1:0] got,
                               input logic [ACC_W-1:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic clear_window_sums();
        prev_sample  = '0;
        sample_pos   = 0;
        window_open  = 1'b0;
        wrapped      = 1'b0;
        sum_run      = '0;
        diff_run     = '0;
        weighted_run = '0;
    endtask

    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] smp, input logic closes);
        window_sums_t sums;
        logic [SAMPLE_W-1:0] step;
        step = (smp > prev_sample) ? smp - prev_sample : prev_sample - smp;
        if (window_open) begin
            diff_run = diff_run + ACC_W'(step);
        end
        sum_run      = sum_run + ACC_W'(smp);
        weighted_run = weighted_run + ACC_W'(sample_pos) * ACC_W'(smp);
        prev_sample  = smp;
        if (closes) begin
            sums.total          = sum_run;
            sums.abs_diff_total = diff_run;
            sums.weighted_total = weight_enable ? weighted_run : '0;
            sums.too_long       = wrapped;
            expected_sums.push_back(sums);
            clear_window_sums();
        end else begin
            window_open = 1'b1;
            // Weights restart from zero once the window outgrows the counter.
            if (sample_pos + 1 >= WINDOW_MAX) begin
                sample_pos = 0;
                wrapped    = 1'b1;
            end else begin
                sample_pos++;
            end
        end
    endtask

    task automatic check_window_sums();
        window_sums_t want;
        if (expected_sums.size() == 0) begin
            report_mismatch("result beat with no window closed", m_tdata[ACC_W-1:0], '0);
        end else begin
            want = expected_sums.pop_front();
            check_field("total", m_tdata[ACC_W-1:0], want.total);
            check_field("abs_diff_total", m_tdata[2*ACC_W-1:ACC_W], want.abs_diff_total);
            check_field("weighted_total", m_tdata[3*ACC_W-1:2*ACC_W], want.weighted_total);
            check_field("too_long", ACC_W'(m_tuser), ACC_W'(want.too_long));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            weight_enable = 1'b1;
            clear_window_sums();
        end else begin
            if (cfg_valid && cfg_ready) begin
                weight_enable = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                accumulate_sample(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_window_sums();
            end
        end
    end

    // The receiver changes its stall behaviour every so often.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(32, 256);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= (cycle_count % 4 == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: pick_sample = '0;
            1: pick_sample = '1;
            2: pick_sample = SAMPLE_W'($urandom_range(0, 255));
            3: pick_sample = {24'hFFFFFF, 8'($urandom_range(0, 255))};
            4: pick_sample = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            default: pick_sample = $urandom;
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic closes);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= closes;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic send_run(input int count, input logic closes);
        for (int i = 0; i < count; i++) begin
            send_sample(pick_sample(), closes && (i == count - 1));
        end
    endtask

    // Holds the sender until every closed window has come back and the pipeline is empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_weight_enable(input logic value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_single_sample_windows();
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'h0000_0001, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
    endtask

    task automatic test_extreme_differences();
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'd7, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd100, 1'b1);
    endtask

    task automatic test_weight_disabled();
        write_weight_enable(1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'd5, 1'b1);
        write_weight_enable(1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFE, 1'b1);
    endtask

    // The weighted sum keeps accumulating; only the setting at the closing beat counts.
    task automatic test_setting_changed_mid_window();
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'hFFFF_0000, 1'b0);
        send_sample(32'h0000_FFFF, 1'b0);
        write_weight_enable(1'b0);
        send_sample(32'hDEAD_BEEF, 1'b1);
        send_sample(32'h0F0F_0F0F, 1'b0);
        write_weight_enable(1'b1);
        send_sample(32'hF0F0_F0F0, 1'b1);
    endtask

    // One window just past the counter range, so the weights restart and the flag is set.
    task automatic test_long_windows();
        send_run(WINDOW_MAX + 2, 1'b1);
    endtask

    task automatic test_random_windows();
        int sent;
        int len;
        int split;
        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 6);
                7, 8:                len = $urandom_range(7, 40);
                default:             len = $urandom_range(41, 120);
            endcase
            split = 0;
            if (len > 1 && $urandom_range(0, 9) == 0) begin
                split = $urandom_range(1, len - 1);
            end
            if (split > 0) begin
                send_run(split, 1'b0);
                write_weight_enable(1'($urandom_range(0, 1)));
                send_run(len - split, 1'b1);
            end else begin
                if ($urandom_range(0, 11) == 0) begin
                    write_weight_enable(1'($urandom_range(0, 1)));
                end
                send_run(len, 1'b1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_sample_windows();
        test_extreme_differences();
        test_weight_disabled();
        test_setting_changed_mid_window();
        test_long_windows();
        test_random_windows();
        drain_results();
        repeat (RESULT_LATENCY * 4) @(posedge aclk);
        if (expected_sums.size() != 0) begin
            report_mismatch("windows left without a result",
                            ACC_W'(expected_sums.size()), '0);
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
